@@ sv/msci_pkg.sv @@
`timescale 1ns / 1ps
package msci_pkg;

  localparam int COORD_W = 28;
  localparam int SAMPLE_W = 16;
  localparam int SIDE_W = 16;
  localparam int DIM_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_LANES = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ISO_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DIM  = 2'd2;

  // Lane slots in emission order before any saddle rotation.
  localparam int LANE_BOTTOM = 0;
  localparam int LANE_LEFT   = 1;
  localparam int LANE_TOP    = 2;
  localparam int LANE_RIGHT  = 3;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t interp;
    coord_t other;
  } lane_res_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vtx_t;

  // Four steps of restoring division: brings in four dividend bits and
  // returns the new partial remainder above four quotient bits.
  function automatic logic [19:0] div_step4(logic [15:0] rem, logic [3:0] nib,
                                            logic [15:0] den);
    logic [16:0] r;
    logic [3:0]  q;
    r = {1'b0, rem};
    q = '0;
    for (int i = 3; i >= 0; i--) begin
      r = {r[15:0], nib[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return {r[15:0], q};
  endfunction

endpackage

@@ sv/msci_in_if.sv @@
`timescale 1ns / 1ps
interface msci_in_if #(parameter int INDEX_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic signed [15:0]    corner_ll;
  logic signed [15:0]    corner_lr;
  logic signed [15:0]    corner_ul;
  logic signed [15:0]    corner_ur;
  logic [INDEX_BITS-1:0] cell_col;
  logic [INDEX_BITS-1:0] cell_row;

  modport source(output valid, corner_ll, corner_lr, corner_ul, corner_ur, cell_col,
                 cell_row, input ready);
  modport sink(input valid, corner_ll, corner_lr, corner_ul, corner_ur, cell_col,
               cell_row, output ready);
endinterface

@@ sv/msci_out_if.sv @@
`timescale 1ns / 1ps
interface msci_out_if;
  logic        valid;
  logic        ready;
  logic [27:0] vertex_x;
  logic [27:0] vertex_y;
  logic        last_vertex;

  modport source(output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink(input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

@@ sv/msci_lane.sv @@
`timescale 1ns / 1ps
module msci_lane (
  input  logic              clk,
  input  logic              en,
  input  msci_pkg::coord_t  a,
  input  logic [15:0]       d,
  input  logic [15:0]       p,
  input  logic [15:0]       den,
  input  msci_pkg::coord_t  other,
  output msci_pkg::lane_res_t res
);
  import msci_pkg::*;

  // Product stage, then four stages of four quotient bits each.
  logic [31:0] prod;
  coord_t      a_p, o_p;
  logic [15:0] den_p;

  logic [15:0] rem_s [4];
  logic [15:0] low_s [4];
  logic [15:0] quo_s [4];
  coord_t      a_s   [4];
  coord_t      o_s   [4];
  logic [15:0] den_s [4];

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= p * d;
      a_p   <= a;
      o_p   <= other;
      den_p <= den;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_div
    logic [15:0] rem_in, low_in, quo_in, den_in;
    coord_t      a_in, o_in;
    logic [19:0] step;
    if (k == 0) begin : g_first
      assign rem_in = prod[31:16];
      assign low_in = prod[15:0];
      assign quo_in = '0;
      assign den_in = den_p;
      assign a_in   = a_p;
      assign o_in   = o_p;
    end else begin : g_next
      assign rem_in = rem_s[k-1];
      assign low_in = low_s[k-1];
      assign quo_in = quo_s[k-1];
      assign den_in = den_s[k-1];
      assign a_in   = a_s[k-1];
      assign o_in   = o_s[k-1];
    end
    assign step = div_step4(rem_in, low_in[15:12], den_in);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= step[19:4];
        low_s[k] <= {low_in[11:0], 4'b0000};
        quo_s[k] <= {quo_in[11:0], step[3:0]};
        den_s[k] <= den_in;
        a_s[k]   <= a_in;
        o_s[k]   <= o_in;
      end
    end
  end

  // The quotient never exceeds the edge length, so the sum stays on the edge.
  assign res.interp = a_s[3] + COORD_W'(quo_s[3]);
  assign res.other  = o_s[3];
endmodule

@@ sv/msci_merge.sv @@
`timescale 1ns / 1ps
module msci_merge (
  input  logic               clk,
  input  logic               rst,
  input  logic               cell_valid,
  output logic               cell_ready,
  input  msci_pkg::vtx_t     vtx [4],
  input  logic [3:0]         mask,
  input  logic               rotate,
  msci_out_if.source         vertex_out
);
  import msci_pkg::*;

  vtx_t       slot [4];
  logic [3:0] pend;
  logic [3:0] pend_rest;
  logic       load, fire;
  vtx_t       cur;

  assign pend_rest  = pend & (pend - 4'd1);
  assign fire       = vertex_out.valid && vertex_out.ready;
  assign cell_ready = (pend == 4'd0) || ((pend_rest == 4'd0) && vertex_out.ready);
  assign load       = cell_valid && cell_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (load) begin
      if (rotate) begin
        pend <= {mask[LANE_LEFT], mask[LANE_RIGHT], mask[LANE_TOP], mask[LANE_BOTTOM]};
      end else begin
        pend <= mask;
      end
    end else if (fire) begin
      pend <= pend_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot[0] <= vtx[LANE_BOTTOM];
      if (rotate) begin
        slot[1] <= vtx[LANE_TOP];
        slot[2] <= vtx[LANE_RIGHT];
        slot[3] <= vtx[LANE_LEFT];
      end else begin
        slot[1] <= vtx[LANE_LEFT];
        slot[2] <= vtx[LANE_TOP];
        slot[3] <= vtx[LANE_RIGHT];
      end
    end
  end

  always_comb begin
    if (pend[0]) begin
      cur = slot[0];
    end else if (pend[1]) begin
      cur = slot[1];
    end else if (pend[2]) begin
      cur = slot[2];
    end else begin
      cur = slot[3];
    end
  end

  assign vertex_out.valid       = (pend != 4'd0);
  assign vertex_out.vertex_x    = cur.x;
  assign vertex_out.vertex_y    = cur.y;
  assign vertex_out.last_vertex = (pend_rest == 4'd0);
endmodule

@@ sv/marching_squares_cell_isoline_core.sv @@
`timescale 1ns / 1ps
// Marching-squares isoline cell evaluator. Each input item is one grid cell
// (four corner samples and the column and row of its lower-left node); for
// every edge that the isoline crosses, one vertex item leaves, in the order
// bottom, left, top, right, or bottom, top, right, left for a saddle whose
// asymptote ratio is not negative or whose cell side is zero. A cell whose
// corners all agree yields no vertex. A new cell can be taken in every cycle
// unless the output holds the pipeline; the output channel moves one vertex
// per cycle while its receiver is ready, so a cell with n crossings holds the
// output for n vertex transfers, at most four. A cell passes three front
// stages, a multiply stage and four division stages in each lane, then the
// output register. Configuration must be written only while the block is idle.
module marching_squares_cell_isoline_core #(
  parameter int INDEX_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [msci_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  msci_in_if.sink                        cell_in,
  msci_out_if.source                     vertex_out
);
  import msci_pkg::*;

  localparam int CW = (INDEX_BITS + 1 > DIM_W) ? INDEX_BITS + 1 : DIM_W;
  localparam int NSTG = 8;

  // Configuration registers.
  logic signed [SAMPLE_W-1:0] iso_level;
  logic [SIDE_W-1:0]          cell_side;
  logic [DIM_W-1:0]           grid_dim;

  always_ff @(posedge clk) begin
    if (rst) begin
      iso_level <= '0;
      cell_side <= 16'd256;
      grid_dim  <= 13'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ISO_LEVEL: iso_level <= cfg_data;
        CFG_CELL_SIDE: cell_side <= cfg_data;
        CFG_GRID_DIM:  grid_dim  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it holds only when the last stage has
  // a cell that the output register cannot yet take.
  logic [NSTG-1:0] vld;
  logic            adv, merge_ready;

  assign adv           = !vld[NSTG-1] || merge_ready;
  assign cell_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], cell_in.valid};
    end
  end

  // Stage one: clamp the node indices and keep the increments 1 + index.
  function automatic logic [13:0] node_inc(logic [CW-1:0] idx, logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] c;
    if (idx > CW'(lim)) begin
      c = lim;
    end else begin
      c = DIM_W'(idx);
    end
    return {1'b0, c} + 14'd1;
  endfunction

  logic [DIM_W-1:0]        lim;
  logic [INDEX_BITS:0]     col1, row1;
  logic signed [15:0]      f_ll, f_lr, f_ul, f_ur;
  logic [13:0]             inc_c0, inc_c1, inc_r0, inc_r1;

  assign lim  = (grid_dim == '0) ? '0 : grid_dim - 13'd1;
  assign col1 = {1'b0, cell_in.cell_col} + (INDEX_BITS + 1)'(1);
  assign row1 = {1'b0, cell_in.cell_row} + (INDEX_BITS + 1)'(1);

  always_ff @(posedge clk) begin
    if (adv) begin
      f_ll   <= cell_in.corner_ll;
      f_lr   <= cell_in.corner_lr;
      f_ul   <= cell_in.corner_ul;
      f_ur   <= cell_in.corner_ur;
      inc_c0 <= node_inc(CW'(cell_in.cell_col), lim);
      inc_c1 <= node_inc(CW'(col1), lim);
      inc_r0 <= node_inc(CW'(cell_in.cell_row), lim);
      inc_r1 <= node_inc(CW'(row1), lim);
    end
  end

  // Stage two: node coordinates, corner classification, interpolation
  // magnitudes and the saddle decision.
  function automatic coord_t sat_coord(logic [29:0] v);
    return (v[29:28] != 2'b00) ? '1 : v[27:0];
  endfunction

  function automatic logic [15:0] abs17(logic signed [16:0] v);
    return (v < 0) ? 16'(-v) : 16'(v);
  endfunction

  logic signed [16:0] iso_x, ll_x, lr_x, ul_x, ur_x;
  logic               s_ll, s_lr, s_ul, s_ur;
  logic signed [16:0] sd_num;
  logic signed [17:0] sd_den;
  logic               sd_neg, saddle;
  logic [3:0]         mask_c;

  assign iso_x = {iso_level[15], iso_level};
  assign ll_x  = {f_ll[15], f_ll};
  assign lr_x  = {f_lr[15], f_lr};
  assign ul_x  = {f_ul[15], f_ul};
  assign ur_x  = {f_ur[15], f_ur};
  assign s_ll  = f_ll > iso_level;
  assign s_lr  = f_lr > iso_level;
  assign s_ul  = f_ul > iso_level;
  assign s_ur  = f_ur > iso_level;

  assign mask_c[LANE_BOTTOM] = s_ll != s_lr;
  assign mask_c[LANE_LEFT]   = s_ll != s_ul;
  assign mask_c[LANE_TOP]    = s_ul != s_ur;
  assign mask_c[LANE_RIGHT]  = s_lr != s_ur;

  // Asymptote ratio (ll - ul) / (ll + ur - ul - lr): only its sign matters.
  assign sd_num = ll_x - ul_x;
  assign sd_den = {ll_x[16], ll_x} + {ur_x[16], ur_x} - {ul_x[16], ul_x}
                - {lr_x[16], lr_x};
  assign sd_neg = ((sd_den > 0) && (sd_num < 0)) || ((sd_den < 0) && (sd_num > 0))
               || ((sd_den == 0) && (sd_num < 0));
  assign saddle = (s_ll != s_lr) && (s_ll != s_ul) && (s_ll == s_ur);

  coord_t      x0, x1, y0, y2;
  logic [15:0] p2 [4];
  logic [15:0] dn2 [4];
  logic [3:0]  mask2;
  logic        rot2;

  always_ff @(posedge clk) begin
    if (adv) begin
      x0 <= sat_coord(cell_side * inc_c0);
      x1 <= sat_coord(cell_side * inc_c1);
      y0 <= sat_coord(cell_side * inc_r0);
      y2 <= sat_coord(cell_side * inc_r1);
      p2[LANE_BOTTOM]  <= abs17(iso_x - ll_x);
      dn2[LANE_BOTTOM] <= abs17(lr_x - ll_x);
      p2[LANE_LEFT]    <= abs17(iso_x - ll_x);
      dn2[LANE_LEFT]   <= abs17(ul_x - ll_x);
      p2[LANE_TOP]     <= abs17(iso_x - ul_x);
      dn2[LANE_TOP]    <= abs17(ur_x - ul_x);
      p2[LANE_RIGHT]   <= abs17(iso_x - lr_x);
      dn2[LANE_RIGHT]  <= abs17(ur_x - lr_x);
      mask2 <= mask_c;
      rot2  <= saddle && !(sd_neg && (cell_side != '0));
    end
  end

  // Stage three: edge lengths. Adjacent clamped nodes differ by at most one
  // cell side, so sixteen bits hold them. Each crossing is then
  // a + |iso - fa| * (b - a) / |fb - fa|, which equals the truncated quotient
  // because the fraction is never negative on a crossed edge.
  coord_t      la [4], lo [4];
  logic [15:0] ld [4], lp [4], lden [4];
  logic [3:0]  mask3;
  logic        rot3;

  always_ff @(posedge clk) begin
    if (adv) begin
      la[LANE_BOTTOM] <= x0; ld[LANE_BOTTOM] <= 16'(x1 - x0); lo[LANE_BOTTOM] <= y0;
      la[LANE_LEFT]   <= y0; ld[LANE_LEFT]   <= 16'(y2 - y0); lo[LANE_LEFT]   <= x0;
      la[LANE_TOP]    <= x0; ld[LANE_TOP]    <= 16'(x1 - x0); lo[LANE_TOP]    <= y2;
      la[LANE_RIGHT]  <= y0; ld[LANE_RIGHT]  <= 16'(y2 - y0); lo[LANE_RIGHT]  <= x1;
      lp    <= p2;
      lden  <= dn2;
      mask3 <= mask2;
      rot3  <= rot2;
    end
  end

  // Lanes: one per edge, five stages deep.
  lane_res_t lres [4];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    msci_lane u_lane (
      .clk  (clk),
      .en   (adv),
      .a    (la[l]),
      .d    (ld[l]),
      .p    (lp[l]),
      .den  (lden[l]),
      .other(lo[l]),
      .res  (lres[l])
    );
  end

  // Crossing mask and saddle decision travel beside the lanes.
  logic [3:0] mask_d [5];
  logic       rot_d  [5];

  always_ff @(posedge clk) begin
    if (adv) begin
      mask_d[0] <= mask3;
      rot_d[0]  <= rot3;
      for (int i = 1; i < 5; i++) begin
        mask_d[i] <= mask_d[i-1];
        rot_d[i]  <= rot_d[i-1];
      end
    end
  end

  // Bottom and top lanes interpolate along x, left and right along y.
  vtx_t vtx [4];

  assign vtx[LANE_BOTTOM] = '{x: lres[LANE_BOTTOM].interp, y: lres[LANE_BOTTOM].other};
  assign vtx[LANE_LEFT]   = '{x: lres[LANE_LEFT].other,    y: lres[LANE_LEFT].interp};
  assign vtx[LANE_TOP]    = '{x: lres[LANE_TOP].interp,    y: lres[LANE_TOP].other};
  assign vtx[LANE_RIGHT]  = '{x: lres[LANE_RIGHT].other,   y: lres[LANE_RIGHT].interp};

  msci_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .cell_valid(vld[NSTG-1]),
    .cell_ready(merge_ready),
    .vtx       (vtx),
    .mask      (mask_d[4]),
    .rotate    (rot_d[4]),
    .vertex_out(vertex_out)
  );
endmodule

@@ sv/msci_checker.sv @@
`timescale 1ns / 1ps
module msci_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [27:0] vertex_x,
  input logic [27:0] vertex_y,
  input logic        last_vertex
);
  // A vertex waiting on a stalled output keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(vertex_x) && $stable(vertex_y)
                                && $stable(last_vertex))
    else $error("stalled vertex changed");

  // Nothing is pending straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("vertex shown after reset");

  // Input back-pressure only arises from a vertex waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no vertex pending");

  // A cell's vertices leave without a gap until its last one.
  a_cell_contig: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_vertex |=> out_valid)
    else $error("cell vertices interrupted");
endmodule

bind marching_squares_cell_isoline_core msci_checker u_msci_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (cell_in.ready),
  .out_valid  (vertex_out.valid),
  .out_ready  (vertex_out.ready),
  .vertex_x   (vertex_out.vertex_x),
  .vertex_y   (vertex_out.vertex_y),
  .last_vertex(vertex_out.last_vertex)
);
